>>> src/wslt_pkg.sv
`timescale 1ns / 1ps

package wslt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;

   localparam int MAC_W   = 48;
   localparam int LEVEL_W = 8;
   localparam int MAKER_W = 3;
   localparam int WORD_W  = MAC_W + 1 + LEVEL_W + MAKER_W;

   localparam logic [7:0] FRAME_BEACON = 8'h80;
   localparam logic [7:0] FRAME_PROBE  = 8'h40;
   localparam int         LOCAL_BIT    = 1;

   localparam logic [11:0] SSID_HDR_END = 12'd38;
   localparam logic [7:0]  SSID_MAX_LEN = 8'd32;
   localparam logic [7:0]  SSID_TAG     = 8'd0;

   localparam logic [1:0] OUT_HIT    = 2'd0;
   localparam logic [1:0] OUT_INSERT = 2'd1;
   localparam logic [1:0] OUT_FULL   = 2'd2;
   localparam logic [1:0] OUT_IGNORE = 2'd3;

   localparam logic [1:0] SSID_PRESENT = 2'd0;
   localparam logic [1:0] SSID_HIDDEN  = 2'd1;
   localparam logic [1:0] SSID_UNKNOWN = 2'd2;
   localparam logic [1:0] SSID_NONE    = 2'd3;

   localparam logic [2:0] VEND_UNKNOWN = 3'd0;
   localparam logic [2:0] VEND_RANDOM  = 3'd1;
   localparam logic [2:0] VEND_A       = 3'd2;
   localparam logic [2:0] VEND_S       = 3'd3;
   localparam logic [2:0] VEND_X       = 3'd4;
   localparam logic [2:0] VEND_T       = 3'd5;
   localparam logic [2:0] VEND_C       = 3'd6;

   typedef struct packed {
      logic [MAC_W-1:0]   mac;
      logic               router;
      logic [LEVEL_W-1:0] level;
      logic [MAKER_W-1:0] maker;
   } entry_type;

   function automatic logic [2:0] vendor_of(input logic [MAC_W-1:0] mac);
      logic [23:0] oui;
      logic [2:0]  code;
      oui = mac[47:24];
      code = VEND_UNKNOWN;
      if (oui[16+LOCAL_BIT]) begin
         code = VEND_RANDOM;
      end else begin
         case (oui)
            24'hF01898, 24'hACBC32: code = VEND_A;
            24'hA89CED, 24'h5CE8EB: code = VEND_S;
            24'h640980, 24'h886C60: code = VEND_X;
            24'hD84567:             code = VEND_T;
            24'h38D57A:             code = VEND_C;
            default:                code = VEND_UNKNOWN;
         endcase
      end
      return code;
   endfunction

   function automatic logic [1:0] ssid_class(input logic [11:0] flen,
                                             input logic [7:0]  tag,
                                             input logic [7:0]  tlen);
      logic [12:0] need;
      logic [1:0]  cls;
      need = {1'b0, SSID_HDR_END} + {5'b0, tlen};
      if (flen <= SSID_HDR_END) begin
         cls = SSID_HIDDEN;
      end else if (tag == SSID_TAG && tlen <= SSID_MAX_LEN && need <= {1'b0, flen}) begin
         cls = (tlen == 8'd0) ? SSID_HIDDEN : SSID_PRESENT;
      end else begin
         cls = SSID_UNKNOWN;
      end
      return cls;
   endfunction

endpackage

>>> src/wslt_ram.sv
`timescale 1ns / 1ps

module wslt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/wifi_station_learning_table.sv
`timescale 1ns / 1ps

// Learns source addresses of beacons (routers) and probe requests (clients) into a table
// held in one single-port-read memory. For a beacon or probe request the stored addresses
// are read one per cycle through the memory read port, overlapped with the compare of the
// previous read, and the scan stops at the first match or after the last entry. Any other
// frame type skips the scan. One item is in work at a time; a finished result waits in the
// output register. The table needs no clearing after reset: only slots below the entry
// count are ever compared.
module wifi_station_learning_table
   import wslt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_frame_type,
   input  logic [47:0]       req_src_mac,
   input  logic signed [7:0] req_rssi,
   input  logic [11:0]       req_frame_length,
   input  logic [7:0]        req_ssid_tag_num,
   input  logic [7:0]        req_ssid_tag_len,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_outcome,
   output logic [5:0]        rsp_entry_index,
   output logic [2:0]        rsp_vendor_code,
   output logic [1:0]        rsp_ssid_status,
   output logic [6:0]        rsp_router_count,
   output logic [6:0]        rsp_client_count
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   router_ff, router_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               cmp_valid_ff, cmp_valid_in;

   logic [MAC_W-1:0]   mac_ff, mac_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               beacon_ff, beacon_in;
   logic [2:0]         vendor_ff, vendor_in;

   logic [1:0]         res_outcome_ff, res_outcome_in;
   logic [5:0]         res_index_ff, res_index_in;
   logic [2:0]         res_vendor_ff, res_vendor_in;
   logic [1:0]         res_ssid_ff, res_ssid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_outcome_ff, rsp_outcome_in;
   logic [5:0]         rsp_index_ff, rsp_index_in;
   logic [2:0]         rsp_vendor_ff, rsp_vendor_in;
   logic [1:0]         rsp_ssid_ff, rsp_ssid_in;
   logic [6:0]         rsp_router_ff, rsp_router_in;
   logic [6:0]         rsp_client_ff, rsp_client_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_word;
   entry_type          rd_word;
   logic [WORD_W-1:0]  rd_bits;

   logic               hit;
   logic [CNT_W-1:0]   client_cnt;
   logic [CNT_W+6:0]   router_wide;
   logic [CNT_W+6:0]   client_wide;
   logic [CNT_W+5:0]   count_wide;
   logic [IDX_W+5:0]   cmp_idx_wide;

   wslt_ram #(
      .WIDTH(WORD_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_word),
      .rd_addr(idx_ff[IDX_W-1:0]),
      .rd_data(rd_bits)
   );

   assign rd_word      = entry_type'(rd_bits);
   assign hit          = cmp_valid_ff && (rd_word.mac == mac_ff);
   assign client_cnt   = count_ff - router_ff;
   assign router_wide  = (CNT_W + 7)'(router_ff);
   assign client_wide  = (CNT_W + 7)'(client_cnt);
   assign count_wide   = (CNT_W + 6)'(count_ff);
   assign cmp_idx_wide = (IDX_W + 6)'(cmp_idx_ff);

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      router_in      = router_ff;
      idx_in         = idx_ff;
      cmp_idx_in     = cmp_idx_ff;
      cmp_valid_in   = cmp_valid_ff;
      mac_in         = mac_ff;
      level_in       = level_ff;
      beacon_in      = beacon_ff;
      vendor_in      = vendor_ff;
      res_outcome_in = res_outcome_ff;
      res_index_in   = res_index_ff;
      res_vendor_in  = res_vendor_ff;
      res_ssid_in    = res_ssid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_vendor_in  = rsp_vendor_ff;
      rsp_ssid_in    = rsp_ssid_ff;
      rsp_router_in  = rsp_router_ff;
      rsp_client_in  = rsp_client_ff;
      wr_en          = 1'b0;
      wr_addr        = cmp_idx_ff;
      wr_word        = rd_word;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mac_in       = req_src_mac;
               level_in     = req_rssi;
               beacon_in    = (req_frame_type == FRAME_BEACON);
               vendor_in    = vendor_of(req_src_mac);
               idx_in       = '0;
               cmp_valid_in = 1'b0;
               res_index_in = '0;
               res_vendor_in = VEND_UNKNOWN;
               if (req_frame_type == FRAME_BEACON) begin
                  res_ssid_in = ssid_class(req_frame_length, req_ssid_tag_num,
                                           req_ssid_tag_len);
               end else begin
                  res_ssid_in = SSID_NONE;
               end
               if (req_frame_type == FRAME_BEACON || req_frame_type == FRAME_PROBE) begin
                  state_in = ST_SCAN;
               end else begin
                  res_outcome_in = OUT_IGNORE;
                  state_in       = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               wr_en          = 1'b1;
               wr_addr        = cmp_idx_ff;
               wr_word        = rd_word;
               wr_word.level  = level_ff;
               res_outcome_in = OUT_HIT;
               res_index_in   = cmp_idx_wide[5:0];
               res_vendor_in  = rd_word.maker;
               cmp_valid_in   = 1'b0;
               state_in       = ST_DONE;
            end else if (idx_ff < count_ff) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = idx_ff[IDX_W-1:0];
               idx_in       = idx_ff + 1'b1;
            end else begin
               cmp_valid_in = 1'b0;
               state_in     = ST_DONE;
               if (count_ff < DEPTH_C) begin
                  wr_en          = 1'b1;
                  wr_addr        = count_ff[IDX_W-1:0];
                  wr_word.mac    = mac_ff;
                  wr_word.router = beacon_ff;
                  wr_word.level  = level_ff;
                  wr_word.maker  = vendor_ff;
                  count_in       = count_ff + 1'b1;
                  if (beacon_ff) begin
                     router_in = router_ff + 1'b1;
                  end
                  res_outcome_in = OUT_INSERT;
                  res_index_in   = count_wide[5:0];
                  res_vendor_in  = vendor_ff;
               end else begin
                  res_outcome_in = OUT_FULL;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = res_outcome_ff;
               rsp_index_in   = res_index_ff;
               rsp_vendor_in  = res_vendor_ff;
               rsp_ssid_in    = res_ssid_ff;
               rsp_router_in  = router_wide[6:0];
               rsp_client_in  = client_wide[6:0];
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         router_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         router_ff    <= router_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      mac_ff         <= mac_in;
      level_ff       <= level_in;
      beacon_ff      <= beacon_in;
      vendor_ff      <= vendor_in;
      res_outcome_ff <= res_outcome_in;
      res_index_ff   <= res_index_in;
      res_vendor_ff  <= res_vendor_in;
      res_ssid_ff    <= res_ssid_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_vendor_ff  <= rsp_vendor_in;
      rsp_ssid_ff    <= rsp_ssid_in;
      rsp_router_ff  <= rsp_router_in;
      rsp_client_ff  <= rsp_client_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_entry_index  = rsp_index_ff;
   assign rsp_vendor_code  = rsp_vendor_ff;
   assign rsp_ssid_status  = rsp_ssid_ff;
   assign rsp_router_count = rsp_router_ff;
   assign rsp_client_count = rsp_client_ff;

endmodule

>>> tb/sv/wifi_station_learning_table_tb.sv
`timescale 1ns / 1ps

module wifi_station_learning_table_tb;
   import wslt_pkg::*;

   localparam int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH;
   localparam int RANDOM_ITEMS = 1300;

   typedef struct {
      logic [1:0] outcome;
      logic [5:0] slot;
      logic [2:0] vendor;
      logic [1:0] ssid;
      logic [6:0] routers;
      logic [6:0] clients;
   } station_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [7:0]        req_frame_type;
   logic [47:0]       req_src_mac;
   logic signed [7:0] req_rssi;
   logic [11:0]       req_frame_length;
   logic [7:0]        req_ssid_tag_num;
   logic [7:0]        req_ssid_tag_len;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_outcome;
   logic [5:0]        rsp_entry_index;
   logic [2:0]        rsp_vendor_code;
   logic [1:0]        rsp_ssid_status;
   logic [6:0]        rsp_router_count;
   logic [6:0]        rsp_client_count;

   // learned stations as the block should hold them
   logic [47:0] known_addr [TABLE_DEPTH];
   logic [2:0]  known_maker [TABLE_DEPTH];
   int          known_count;
   int          router_seen;

   station_result_type pending_results[$];
   int                 mismatches;
   bit                 steady_flow;

   wifi_station_learning_table i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_type   (req_frame_type),
      .req_src_mac      (req_src_mac),
      .req_rssi         (req_rssi),
      .req_frame_length (req_frame_length),
      .req_ssid_tag_num (req_ssid_tag_num),
      .req_ssid_tag_len (req_ssid_tag_len),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_outcome      (rsp_outcome),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_vendor_code  (rsp_vendor_code),
      .rsp_ssid_status  (rsp_ssid_status),
      .rsp_router_count (rsp_router_count),
      .rsp_client_count (rsp_client_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [23:0] oui_prefix(input int n);
      case (n)
         0:       return 24'hF01898;
         1:       return 24'hACBC32;
         2:       return 24'hA89CED;
         3:       return 24'h5CE8EB;
         4:       return 24'h640980;
         5:       return 24'h886C60;
         6:       return 24'hD84567;
         default: return 24'h38D57A;
      endcase
   endfunction

   function automatic logic [2:0] oui_maker(input int n);
      case (n)
         0, 1:    return VEND_A;
         2, 3:    return VEND_S;
         4, 5:    return VEND_X;
         6:       return VEND_T;
         default: return VEND_C;
      endcase
   endfunction

   function automatic logic [2:0] maker_of(input logic [47:0] mac);
      logic [2:0] code;
      code = VEND_UNKNOWN;
      // locally administered bit of the first byte
      if (mac[41]) begin
         code = VEND_RANDOM;
      end else begin
         for (int n = 0; n < 8; n++) begin
            if (mac[47:24] == oui_prefix(n)) begin
               code = oui_maker(n);
            end
         end
      end
      return code;
   endfunction

   function automatic logic [1:0] ssid_kind(input int flen, input int tag, input int tlen);
      if (flen <= SSID_HDR_END) begin
         return SSID_HIDDEN;
      end
      if (tag == SSID_TAG && tlen <= SSID_MAX_LEN && SSID_HDR_END + tlen <= flen) begin
         return (tlen == 0) ? SSID_HIDDEN : SSID_PRESENT;
      end
      return SSID_UNKNOWN;
   endfunction

   function automatic station_result_type learn_frame(input logic [7:0]  ftype,
                                                      input logic [47:0] mac,
                                                      input logic [11:0] flen,
                                                      input logic [7:0]  tag,
                                                      input logic [7:0]  tlen);
      station_result_type r;
      int                 slot;
      logic               is_router;
      r.outcome = OUT_IGNORE;
      r.slot    = '0;
      r.vendor  = VEND_UNKNOWN;
      r.ssid    = SSID_NONE;
      if (ftype == FRAME_BEACON || ftype == FRAME_PROBE) begin
         is_router = (ftype == FRAME_BEACON);
         if (is_router) begin
            r.ssid = ssid_kind(flen, tag, tlen);
         end
         slot = -1;
         for (int i = 0; i < known_count; i++) begin
            if (slot < 0 && known_addr[i] == mac) begin
               slot = i;
            end
         end
         // a hit keeps the stored kind and vendor
         if (slot >= 0) begin
            r.outcome = OUT_HIT;
            r.slot    = 6'(slot);
            r.vendor  = known_maker[slot];
         end else if (known_count < TABLE_DEPTH) begin
            known_addr[known_count]  = mac;
            known_maker[known_count] = maker_of(mac);
            if (is_router) begin
               router_seen++;
            end
            r.outcome = OUT_INSERT;
            r.slot    = 6'(known_count);
            r.vendor  = known_maker[known_count];
            known_count++;
         end else begin
            r.outcome = OUT_FULL;
         end
      end
      r.routers = 7'(router_seen);
      r.clients = 7'(known_count - router_seen);
      return r;
   endfunction

   function automatic int idle_cycles();
      int r;
      if (steady_flow) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [47:0] fresh_address();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) begin
         raw[47:24] = oui_prefix($urandom_range(0, 7));
      end
      return raw[47:0];
   endfunction

   task automatic send_frame(input logic [7:0]        ftype,
                             input logic [47:0]       mac,
                             input logic signed [7:0] level,
                             input logic [11:0]       flen,
                             input logic [7:0]        tag,
                             input logic [7:0]        tlen);
      int gap;
      gap = idle_cycles();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_frame_type   = ftype;
      req_src_mac      = mac;
      req_rssi         = level;
      req_frame_length = flen;
      req_ssid_tag_num = tag;
      req_ssid_tag_len = tlen;
      req_valid        = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(learn_frame(ftype, mac, flen, tag, tlen));
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      station_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result item: outcome %0d", rsp_outcome);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("outcome", want.outcome, rsp_outcome);
            check_field("entry_index", want.slot, rsp_entry_index);
            check_field("vendor_code", want.vendor, rsp_vendor_code);
            check_field("ssid_status", want.ssid, rsp_ssid_status);
            check_field("router_count", want.routers, rsp_router_count);
            check_field("client_count", want.clients, rsp_client_count);
         end
      end
   end

   // result side back-pressure
   always begin
      int stall;
      @(negedge clock);
      rsp_ready = 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clock);
      stall = idle_cycles();
      if (stall > 0) begin
         @(negedge clock);
         rsp_ready = 1'b0;
         repeat (stall - 1) @(negedge clock);
      end
   end

   task automatic test_ignored_frames();
      steady_flow = 1'b1;
      send_frame(8'h00, 48'h0, 8'sd0, 12'd0, 8'd0, 8'd0);
      send_frame(8'hFF, 48'hFFFF_FFFF_FFFF, -8'sd1, 12'hFFF, 8'hFF, 8'hFF);
      send_frame(FRAME_BEACON | 8'h01, 48'hF018_9800_0001, 8'sd10, 12'd60, 8'd0, 8'd5);
      send_frame(FRAME_PROBE ^ 8'h01, 48'h0200_0000_0000, 8'sd20, 12'd60, 8'd0, 8'd5);
      steady_flow = 1'b0;
   endtask

   task automatic test_vendor_prefixes();
      send_frame(FRAME_BEACON, 48'hF018_9812_3456, -8'sd128, 12'd60, 8'd0, 8'd5);
      send_frame(FRAME_PROBE,  48'hACBC_3200_FF00, 8'sd127, 12'd60, 8'd0, 8'd5);
      send_frame(FRAME_BEACON, 48'hA89C_EDFF_FFFF, -8'sd40, 12'd60, 8'd0, 8'd5);
      send_frame(FRAME_PROBE,  48'h5CE8_EB00_0000, -8'sd70, 12'd60, 8'd0, 8'd5);
      send_frame(FRAME_BEACON, 48'h6409_80AB_CDEF, -8'sd55, 12'd60, 8'd0, 8'd5);
      send_frame(FRAME_PROBE,  48'h886C_6065_4321, -8'sd90, 12'd60, 8'd0, 8'd5);
      send_frame(FRAME_BEACON, 48'hD845_670F_0F0F, -8'sd30, 12'd60, 8'd0, 8'd5);
      send_frame(FRAME_PROBE,  48'h38D5_7AF0_F0F0, -8'sd60, 12'd60, 8'd0, 8'd5);
      send_frame(FRAME_BEACON, 48'h0200_0000_0000, 8'sd0, 12'd60, 8'd0, 8'd5);
      send_frame(FRAME_PROBE,  48'hFFFF_FFFF_FFFF, 8'sd1, 12'd60, 8'd0, 8'd5);
   endtask

   task automatic test_ssid_elements();
      send_frame(FRAME_BEACON, 48'h0000_0000_0000, 8'sd5, 12'd38, 8'd0, 8'd0);
      send_frame(FRAME_BEACON, 48'h0000_0000_0001, 8'sd5, 12'd0, 8'd0, 8'd0);
      send_frame(FRAME_BEACON, 48'h0000_0000_0002, 8'sd5, 12'd39, 8'd0, 8'd0);
      send_frame(FRAME_BEACON, 48'h0000_0000_0003, 8'sd5, 12'd39, 8'd0, 8'd1);
      send_frame(FRAME_BEACON, 48'h0000_0000_0004, 8'sd5, 12'd70, 8'd0, 8'd32);
      send_frame(FRAME_BEACON, 48'h0000_0000_0005, 8'sd5, 12'd69, 8'd0, 8'd32);
      send_frame(FRAME_BEACON, 48'hFDFF_FFFF_FFFF, 8'sd5, 12'hFFF, 8'd0, 8'd33);
      send_frame(FRAME_BEACON, 48'h1234_5678_9ABC, 8'sd5, 12'hFFF, 8'hFF, 8'hFF);
   endtask

   task automatic test_kind_mismatch_hits();
      send_frame(FRAME_PROBE, 48'hF018_9812_3456, 8'sd3, 12'd0, 8'd0, 8'd0);
      send_frame(FRAME_BEACON, 48'hACBC_3200_FF00, -8'sd3, 12'd50, 8'd0, 8'd4);
   endtask

   task automatic test_random_traffic();
      int          learned;
      int          pick;
      logic [7:0]  ftype;
      logic [47:0] mac;
      logic [11:0] flen;
      logic [7:0]  tag;
      logic [7:0]  tlen;
      learned = 0;
      while (learned < RANDOM_ITEMS) begin
         steady_flow = ((learned / 160) % 4 == 3);
         pick  = $urandom_range(0, 99);
         ftype = $urandom_range(0, 1) ? FRAME_BEACON : FRAME_PROBE;
         if (pick < 10) begin
            ftype = 8'($urandom);
            if (ftype == FRAME_BEACON || ftype == FRAME_PROBE) begin
               ftype = ftype ^ 8'h01;
            end
            mac = fresh_address();
         end else if (pick < 22 || known_count == 0) begin
            mac = fresh_address();
         end else begin
            mac = known_addr[$urandom_range(0, known_count - 1)];
         end
         flen = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 80));
         tag  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : SSID_TAG;
         tlen = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
         send_frame(ftype, mac, 8'($urandom), flen, tag, tlen);
         learned++;
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_table_full();
      while (known_count < TABLE_DEPTH) begin
         send_frame(FRAME_PROBE, fresh_address(), 8'($urandom), 12'd0, 8'd0, 8'd0);
      end
      send_frame(FRAME_BEACON, fresh_address(), -8'sd50, 12'd50, 8'd0, 8'd5);
      send_frame(FRAME_PROBE, fresh_address(), -8'sd50, 12'd50, 8'd0, 8'd5);
      send_frame(FRAME_BEACON, known_addr[TABLE_DEPTH - 1], 8'sd7, 12'd30, 8'd1, 8'd1);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_frame_type   = '0;
      req_src_mac      = '0;
      req_rssi         = '0;
      req_frame_length = '0;
      req_ssid_tag_num = '0;
      req_ssid_tag_len = '0;
      rsp_ready        = 1'b0;
      known_count      = 0;
      router_seen      = 0;
      mismatches       = 0;
      steady_flow      = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_ignored_frames();
      test_vendor_prefixes();
      test_ssid_elements();
      test_kind_mismatch_hits();
      test_random_traffic();
      test_table_full();

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 16) @(posedge clock);
      if (mismatches == 0) begin
         $display("wifi_station_learning_table test passed");
      end else begin
         $display("wifi_station_learning_table test failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("wifi_station_learning_table test failed");
      $finish;
   end

endmodule
